// File: hdl/blkm_pkg.sv
// Shared types, constants and helpers of the block map allocator.
`default_nettype none

package blkm_pkg;

  // Pool and map geometry
  localparam int POOLS         = 3;
  localparam int TABLE_ENTRIES = 1024;
  localparam int NUM_REGS      = 3;
  localparam int MAP_DEPTH     = POOLS * TABLE_ENTRIES;
  localparam int MAP_AW        = $clog2(MAP_DEPTH);
  localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
  localparam int CUR_W         = ENTRY_W + 1;
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int MAP_W         = USED_W;

  // Field widths
  localparam int POOL_W    = 2;
  localparam int SIZE_W    = 32;
  localparam int OFFSET_W  = 22;
  localparam int USAGE_W   = 10;
  localparam int BS_W      = 13;
  localparam int CFG_IDX_W = 2;
  localparam int DIVD_W    = SIZE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
  localparam int PERM_W    = USED_W + USAGE_W;
  localparam int BOFF_W    = ENTRY_W + BS_W;

  // Constants
  localparam int BS_MAX   = 4096;
  localparam int BS_RESET = 64;
  localparam int PERMILLE = 1000;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BS_POOL0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BS_POOL1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BS_POOL2 = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ALLOC_FAIL = 2'd1,
    STAT_NOT_READY  = 2'd2,
    STAT_BAD_OFFSET = 2'd3
  } status_t;

  typedef struct packed {
    logic                req_type;
    logic [POOL_W-1:0]   pool;
    logic [SIZE_W-1:0]   alloc_size;
    logic [SIZE_W-1:0]   free_offset;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] block_offset;
    logic [USAGE_W-1:0]  usage_permille;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE_LEN,
    ST_FREE_CLR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [BS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // Clamp a block size register: zero acts as one, large values saturate
  function automatic logic [BS_W-1:0] eff_block_size(input logic [BS_W-1:0] b);
    logic [BS_W-1:0] r;
    if (b == '0) begin
      r = BS_W'(1);
    end else if (b > BS_W'(BS_MAX)) begin
      r = BS_W'(BS_MAX);
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/blkm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/blkm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module blkm_div import blkm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BS_W-1:0]      rem_r, rem_nxt;
  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [BS_W-1:0]      dvs_r, dvs_nxt;
  logic [BS_W:0]        trial;
  logic [BS_W:0]        diff;
  logic                 ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  // Load on start, shift one bit per cycle while busy
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVD_W);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// File: hdl/blkm_ctrl.sv
// Request sequencer: clears, scans, marks and releases runs in the block map.
`default_nettype none

module blkm_ctrl import blkm_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire in_t                          in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output out_t                              out_data,
  input  wire logic [POOLS-1:0][BS_W-1:0]   bs_eff,
  output div_req_t                          div_req,
  input  wire div_rsp_t                     div_rsp,
  output logic                              map_we,
  output logic [MAP_AW-1:0]                 map_waddr,
  output logic [MAP_W-1:0]                  map_wdata,
  output logic                              map_re,
  output logic [MAP_AW-1:0]                 map_raddr,
  input  wire logic [MAP_W-1:0]             map_rdata
);

  ctrl_state_t         state_r, state_nxt;
  in_t                 req_r, req_nxt;
  logic                pool_ok_r, pool_ok_nxt;
  logic [BS_W-1:0]     bs_r, bs_nxt;
  logic [USED_W-1:0]   need_r, need_nxt;
  logic [USED_W-1:0]   run_r, run_nxt;
  logic [USED_W-1:0]   cnt_r, cnt_nxt;
  logic [CUR_W-1:0]    cur_r, cur_nxt;
  logic [ENTRY_W-1:0]  pos_r, pos_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [ENTRY_W-1:0]  rd_idx_r, rd_idx_nxt;
  status_t             status_r, status_nxt;
  logic [OFFSET_W-1:0] boff_r, boff_nxt;
  logic [USED_W-1:0]   used_r [POOLS];
  logic [USED_W-1:0]   used_nxt [POOLS];
  logic [POOLS-1:0]    ready_r, ready_nxt;
  logic [MAP_AW-1:0]   clr_addr_r, clr_addr_nxt;
  out_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_accept;
  logic                in_pool_ok;
  logic [BS_W-1:0]     in_bs;
  logic                off_beyond;
  logic                out_free;
  logic [USED_W-1:0]   scan_run;
  logic                scan_issue;
  logic                free_issue;
  logic [MAP_AW-1:0]   pool_base;
  logic [USED_W-1:0]   used_sel;
  logic [USAGE_W-1:0]  permille;

  // Request decode
  assign in_accept  = in_valid && !in_stall;
  assign in_pool_ok = ({1'b0, in_data.pool} < (POOL_W + 1)'(POOLS));
  assign in_bs      = in_pool_ok ? bs_eff[in_data.pool] : BS_W'(1);
  assign off_beyond = ({1'b0, in_data.free_offset} >=
                       (DIVD_W'(in_bs) * DIVD_W'(TABLE_ENTRIES)));
  assign out_free   = !out_valid_r || !out_stall;

  // Map addressing and run tracking
  assign pool_base  = MAP_AW'(req_r.pool) * MAP_AW'(TABLE_ENTRIES);
  assign scan_run   = (map_rdata == '0) ? (run_r + USED_W'(1)) : '0;
  assign scan_issue = (cur_r != '0);
  assign free_issue = (state_r == ST_FREE_CLR) && (cnt_r != '0) &&
                      (cur_r < CUR_W'(TABLE_ENTRIES));

  // Usage of the addressed pool
  assign used_sel = used_r[req_r.pool];
  assign permille = USAGE_W'((PERM_W'(used_sel) * PERM_W'(PERMILLE)) / TABLE_ENTRIES);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == MAP_AW'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          priority if (!in_pool_ok) begin
            state_nxt = ST_DONE;
          end else if (in_data.req_type == REQ_ALLOC) begin
            state_nxt = (in_data.alloc_size == '0) ? ST_DONE : ST_DIV;
          end else if (!ready_r[in_data.pool] || off_beyond) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (req_r.req_type == REQ_ALLOC) begin
            state_nxt = (div_rsp.quotient > DIVD_W'(TABLE_ENTRIES)) ? ST_DONE : ST_SCAN;
          end else begin
            state_nxt = ST_FREE_RD;
          end
        end
      end
      ST_SCAN: begin
        if (rd_v_r && (scan_run == need_r)) begin
          state_nxt = ST_MARK;
        end else if (!rd_v_r && !scan_issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        if (cnt_r == USED_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FREE_RD:  state_nxt = ST_FREE_LEN;
      ST_FREE_LEN: state_nxt = ST_FREE_CLR;
      ST_FREE_CLR: begin
        if (!free_issue && !rd_v_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath, map port and divider control
  always_comb begin
    req_nxt       = req_r;
    pool_ok_nxt   = pool_ok_r;
    bs_nxt        = bs_r;
    need_nxt      = need_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    rd_v_nxt      = rd_v_r;
    rd_idx_nxt    = rd_idx_r;
    status_nxt    = status_r;
    boff_nxt      = boff_r;
    used_nxt      = used_r;
    ready_nxt     = ready_r;
    clr_addr_nxt  = clr_addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    map_we        = 1'b0;
    map_waddr     = '0;
    map_wdata     = '0;
    map_re        = 1'b0;
    map_raddr     = '0;
    div_req       = '0;
    div_req.divisor = in_bs;

    unique case (state_r)
      // Sweep zeros through the whole map after reset
      ST_CLEAR: begin
        map_we       = 1'b1;
        map_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + MAP_AW'(1);
      end

      // Take a request, settle the trivial outcomes, launch the divide
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt     = in_data;
          pool_ok_nxt = in_pool_ok;
          bs_nxt      = in_bs;
          boff_nxt    = '0;
          status_nxt  = STAT_OK;
          priority if (!in_pool_ok) begin
            status_nxt = (in_data.req_type == REQ_ALLOC) ? STAT_ALLOC_FAIL : STAT_BAD_OFFSET;
          end else if (in_data.req_type == REQ_ALLOC) begin
            ready_nxt[in_data.pool] = 1'b1;
            if (in_data.alloc_size == '0) begin
              status_nxt = STAT_ALLOC_FAIL;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = DIVD_W'(in_data.alloc_size) + DIVD_W'(in_bs) - DIVD_W'(1);
            end
          end else if (!ready_r[in_data.pool]) begin
            ready_nxt[in_data.pool] = 1'b1;
            status_nxt              = STAT_NOT_READY;
          end else if (off_beyond) begin
            status_nxt = STAT_BAD_OFFSET;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVD_W'(in_data.free_offset);
          end
        end
      end

      // Block count for allocate, entry index for free
      ST_DIV: begin
        if (div_rsp.done) begin
          if (req_r.req_type == REQ_ALLOC) begin
            if (div_rsp.quotient > DIVD_W'(TABLE_ENTRIES)) begin
              status_nxt = STAT_ALLOC_FAIL;
            end else begin
              need_nxt = div_rsp.quotient[USED_W-1:0];
              cur_nxt  = CUR_W'(TABLE_ENTRIES);
              run_nxt  = '0;
              rd_v_nxt = 1'b0;
            end
          end else begin
            cur_nxt = {1'b0, div_rsp.quotient[ENTRY_W-1:0]};
          end
        end
      end

      // Stream reads downward, count free entries as data returns
      ST_SCAN: begin
        rd_v_nxt = 1'b0;
        if (scan_issue) begin
          map_re     = 1'b1;
          map_raddr  = pool_base + MAP_AW'(cur_r - CUR_W'(1));
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = ENTRY_W'(cur_r - CUR_W'(1));
          cur_nxt    = cur_r - CUR_W'(1);
        end
        if (rd_v_r) begin
          run_nxt = scan_run;
          if (scan_run == need_r) begin
            pos_nxt  = rd_idx_r;
            cur_nxt  = {1'b0, rd_idx_r};
            cnt_nxt  = need_r;
            rd_v_nxt = 1'b0;
          end
        end else if (!scan_issue) begin
          status_nxt = STAT_ALLOC_FAIL;
        end
      end

      // Write the run length into each entry of the run
      ST_MARK: begin
        map_we    = 1'b1;
        map_waddr = pool_base + MAP_AW'(cur_r);
        map_wdata = MAP_W'(need_r);
        cur_nxt   = cur_r + CUR_W'(1);
        cnt_nxt   = cnt_r - USED_W'(1);
        boff_nxt  = OFFSET_W'(BOFF_W'(pos_r) * BOFF_W'(bs_r));
        if (cnt_r == USED_W'(1)) begin
          used_nxt[req_r.pool] = used_r[req_r.pool] + need_r;
          status_nxt           = STAT_OK;
        end
      end

      // Fetch the run length at the freed entry
      ST_FREE_RD: begin
        map_re    = 1'b1;
        map_raddr = pool_base + MAP_AW'(cur_r);
      end

      ST_FREE_LEN: begin
        cnt_nxt    = map_rdata;
        rd_v_nxt   = 1'b0;
        status_nxt = STAT_OK;
      end

      // Read ahead one entry, clear those that hold a length
      ST_FREE_CLR: begin
        rd_v_nxt = 1'b0;
        if (free_issue) begin
          map_re     = 1'b1;
          map_raddr  = pool_base + MAP_AW'(cur_r);
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = cur_r[ENTRY_W-1:0];
          cur_nxt    = cur_r + CUR_W'(1);
          cnt_nxt    = cnt_r - USED_W'(1);
        end
        if (rd_v_r && (map_rdata != '0)) begin
          map_we               = 1'b1;
          map_waddr            = pool_base + MAP_AW'(rd_idx_r);
          used_nxt[req_r.pool] = used_r[req_r.pool] - USED_W'(1);
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.block_offset   = boff_r;
          out_nxt.usage_permille = pool_ok_r ? permille : '0;
        end
      end

      default: begin
        clr_addr_nxt = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      for (int p = 0; p < POOLS; p++) begin
        used_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= rd_v_nxt;
      used_r      <= used_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pool_ok_r <= pool_ok_nxt;
    bs_r      <= bs_nxt;
    need_r    <= need_nxt;
    run_r     <= run_nxt;
    cnt_r     <= cnt_nxt;
    cur_r     <= cur_nxt;
    pos_r     <= pos_nxt;
    rd_idx_r  <= rd_idx_nxt;
    status_r  <= status_nxt;
    boff_r    <= boff_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: hdl/block_map_allocator.sv
// Block map allocator: one allocate or free per item against a per-pool run-length map.
// Allocate: a divide and setup, a downward scan of the pool's entries, then one write
//   per block of the run.
// Free: a divide, a read of the run length, then a clear of each entry of the released run.
// One item at a time: every step goes through the map's single read port and single write port.
// Reset (rst_n low, synchronous) is followed by a pass that zeroes all 3072 map entries.
`default_nettype none

module block_map_allocator import blkm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BS_W-1:0]      cfg_data
);

  logic [BS_W-1:0]            bs_reg_r [NUM_REGS];
  logic [POOLS-1:0][BS_W-1:0] bs_eff;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic                       map_we;
  logic [MAP_AW-1:0]          map_waddr;
  logic [MAP_W-1:0]           map_wdata;
  logic                       map_re;
  logic [MAP_AW-1:0]          map_raddr;
  logic [MAP_W-1:0]           map_rdata;

  assign cfg_ready = 1'b1;

  // Block size registers; writes beyond the list drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        bs_reg_r[r] <= BS_W'(BS_RESET);
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BS_POOL0: bs_reg_r[0] <= cfg_data;
        REG_BS_POOL1: bs_reg_r[1] <= cfg_data;
        REG_BS_POOL2: bs_reg_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp each pool's block size
  always_comb begin
    for (int p = 0; p < POOLS; p++) begin
      bs_eff[p] = eff_block_size(bs_reg_r[p]);
    end
  end

  blkm_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  blkm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  blkm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bs_eff    (bs_eff),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .map_we    (map_we),
    .map_waddr (map_waddr),
    .map_wdata (map_wdata),
    .map_re    (map_re),
    .map_raddr (map_raddr),
    .map_rdata (map_rdata)
  );

  // A reset leaves the block busy with the clearing pass
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken straight after reset");

  // An accepted beat keeps the input held while it is worked on
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while one is in flight");

  // Usage never exceeds the whole table
  a_usage_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.usage_permille <= USAGE_W'(PERMILLE)))
    else $error("usage beyond full scale");

  // Failed requests carry no offset
  a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != STAT_OK)) |-> (out_data.block_offset == '0))
    else $error("offset reported on a failed request");

endmodule

`default_nettype wire
